/* hdl/lstk_pkg.sv */
// ---------------------------------------------------------------------------
// lstk_pkg: shared definitions for the LIFO stack with indexed access
// Widths, operation and status codes, and the command passed from the
// front end to the execution back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lstk_pkg;

   // Number of words the stack holds (legal range 1 to 64).
   localparam int DEPTH       = 8;
   localparam int DATA_W      = 32;
   localparam int OP_W        = 3;
   localparam int DEPTH_IDX_W = 7;
   localparam int STATUS_W    = 2;
   // Entry count must hold DEPTH itself.
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_PEEK   = 3'd2,
      OP_CHANGE = 3'd3,
      OP_DUMP   = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // One classified request waiting for execution.
   typedef struct packed {
      op_type                   op;
      logic signed [DATA_W-1:0] value;
      logic [DEPTH_IDX_W-1:0]   depth;
      logic                     depth_zero;
   } cmd_type;

endpackage

`default_nettype wire

/* hdl/lstk_front.sv */
// ---------------------------------------------------------------------------
// lstk_front: request intake and command queue
// Accepts requests, drops unused operation codes, classifies the rest and
// holds them in a two-entry queue for the execution back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lstk_front
   import lstk_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [OP_W-1:0]          req_op,
   input  wire logic signed [DATA_W-1:0] req_write_value,
   input  wire logic [DEPTH_IDX_W-1:0]   req_depth_index,
   output logic                          cmd_valid,
   output cmd_type                       cmd,
   input  wire logic                     cmd_pop
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   cmd_type    cmd_new;
   logic       op_known;
   logic       enq;

   // Classify the incoming request.
   always_comb begin
      op_known = 1'b0;
      unique case (req_op)
         OP_PUSH, OP_POP, OP_PEEK, OP_CHANGE, OP_DUMP: op_known = 1'b1;
         default:                                      op_known = 1'b0;
      endcase
      cmd_new.op         = op_type'(req_op);
      cmd_new.value      = req_write_value;
      cmd_new.depth      = req_depth_index;
      cmd_new.depth_zero = (req_depth_index == '0);
   end

   // The queue stalls the request side only when both slots are taken.
   assign req_stall = (fill_ff == 2'd2);
   assign enq       = req_valid && !req_stall && op_known;
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];

   // Queue pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = enq ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, enq} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Slot storage needs no reset.
   always_ff @(posedge clock) begin
      if (enq) begin
         slot_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

`default_nettype wire

/* hdl/lstk_back.sv */
// ---------------------------------------------------------------------------
// lstk_back: stack execution engine
// Owns the stack memory and entry count, carries out each command and
// drives the registered response channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lstk_back
   import lstk_pkg::*;
(
   input  wire logic                cmd_valid,
   input  wire cmd_type             cmd,
   output logic                     cmd_pop,
   input  wire logic                clock,
   input  wire logic                reset,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic signed [DATA_W-1:0] rsp_read_value,
   output logic                     rsp_last
);

   typedef enum logic {
      S_IDLE,
      S_WAIT
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [ADDR_W-1:0]        ptr_ff, ptr_in;
   logic                     last_ff, last_in;
   logic                     dump_ff, dump_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rdata_ff;
   logic                     wr_en, rd_en;
   logic [ADDR_W-1:0]        waddr, raddr;
   logic signed [DATA_W-1:0] wdata;

   logic                     out_free;
   logic                     depth_bad;
   logic [ADDR_W-1:0]        pos;
   logic [ADDR_W-1:0]        top;
   logic [ADDR_W-1:0]        ptr_next;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign depth_bad = cmd.depth_zero || (cmd.depth > DEPTH_IDX_W'(count_ff));
   assign pos       = ADDR_W'(DEPTH_IDX_W'(count_ff) - cmd.depth);
   assign top       = ADDR_W'(count_ff - 1'b1);
   assign ptr_next  = ptr_ff - 1'b1;

   // Command execution and response loading.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      last_in       = last_ff;
      dump_in       = dump_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      waddr         = '0;
      wdata         = cmd.value;
      rd_en         = 1'b0;
      raddr         = '0;
      cmd_pop       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop     = 1'b1;
               rsp_last_in = 1'b1;
               unique case (cmd.op)
                  OP_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == CNT_W'(DEPTH)) begin
                        rsp_status_in = ST_FULL;
                        rsp_value_in  = '0;
                     end else begin
                        wr_en         = 1'b1;
                        waddr         = ADDR_W'(count_ff);
                        count_in      = count_ff + 1'b1;
                        rsp_status_in = ST_OK;
                        rsp_value_in  = cmd.value;
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                        rsp_value_in  = '0;
                     end else begin
                        rd_en    = 1'b1;
                        raddr    = top;
                        count_in = count_ff - 1'b1;
                        last_in  = 1'b1;
                        dump_in  = 1'b0;
                        state_in = S_WAIT;
                     end
                  end
                  OP_PEEK: begin
                     if (depth_bad) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_RANGE;
                        rsp_value_in  = '0;
                     end else begin
                        rd_en    = 1'b1;
                        raddr    = pos;
                        last_in  = 1'b1;
                        dump_in  = 1'b0;
                        state_in = S_WAIT;
                     end
                  end
                  OP_CHANGE: begin
                     rsp_valid_in = 1'b1;
                     if (depth_bad) begin
                        rsp_status_in = ST_RANGE;
                        rsp_value_in  = '0;
                     end else begin
                        wr_en         = 1'b1;
                        waddr         = pos;
                        rsp_status_in = ST_OK;
                        rsp_value_in  = cmd.value;
                     end
                  end
                  OP_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                        rsp_value_in  = '0;
                     end else begin
                        rd_en    = 1'b1;
                        raddr    = top;
                        ptr_in   = top;
                        last_in  = (top == '0);
                        dump_in  = 1'b1;
                        state_in = S_WAIT;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         S_WAIT: begin
            // Read data is ready; emit it and fetch the next entry of a dump.
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_value_in  = rdata_ff;
               rsp_last_in   = last_ff;
               if (dump_ff && !last_ff) begin
                  rd_en   = 1'b1;
                  raddr   = ptr_next;
                  ptr_in  = ptr_next;
                  last_in = (ptr_next == '0);
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state with reset; payload registers follow without.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff        <= ptr_in;
      last_ff       <= last_in;
      dump_ff       <= dump_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Stack memory with registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef SYNTHESIS
   // The entry count never passes the stack depth.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds stack depth");

   // Any error response carries a zero value and ends its request.
   a_error_shape : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_value_ff == '0 && rsp_last_ff))
      else $error("error response with non-zero value or without last");

   // While a read is outstanding the entry count holds.
   a_count_hold : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT) |=> $stable(count_ff))
      else $error("entry count changed during a read");

   // A new command is taken only when the response register can load.
   a_pop_free : assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == S_IDLE && out_free && cmd_valid))
      else $error("command taken while response path busy");
`endif

endmodule

`default_nettype wire

/* hdl/lifo_stack_with_indexed_access.sv */
// Request path: push, change and error results pass through the command queue
// and the response register; pop and peek also pass the registered memory read.
// Throughput without rsp_stall: push and change one request per cycle; pop and peek
// hold off the next request until their read returns; dump one response per cycle.
// Reset: synchronous; the stack is empty afterwards and no clearing pass runs.
// ---------------------------------------------------------------------------
// lifo_stack_with_indexed_access: bounded LIFO stack top level
// Front end queues classified requests; back end executes them against the
// stack memory and returns one or more responses per classified request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lifo_stack_with_indexed_access
   import lstk_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [OP_W-1:0]          req_op,
   input  wire logic signed [DATA_W-1:0] req_write_value,
   input  wire logic [DEPTH_IDX_W-1:0]   req_depth_index,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [STATUS_W-1:0]           rsp_status,
   output logic signed [DATA_W-1:0]      rsp_read_value,
   output logic                          rsp_last
);

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   // Request intake and queue.
   lstk_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_write_value (req_write_value),
      .req_depth_index (req_depth_index),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop)
   );

   // Execution against the stack.
   lstk_back u_back (
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop),
      .clock          (clock),
      .reset          (reset),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire
